@@ src/mte_pkg.sv @@
// Shared types, code tables and the control store of the Morse timing encoder.
`timescale 1ns / 1ps

package mte_pkg;

  localparam int DotW = 16;
  localparam int DurW = 19;
  localparam int CharW = 8;
  localparam int SymW = 5;   // longest code: digits have five symbols
  localparam int CntW = 3;
  localparam int OutDataW = 24;

  localparam logic [DotW-1:0] DOT_TICKS_RST = 16'd100;

  localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CharW-1:0] CHAR_A = 8'h41;
  localparam logic [CharW-1:0] CHAR_Z = 8'h5A;
  localparam logic [CharW-1:0] CHAR_0 = 8'h30;
  localparam logic [CharW-1:0] CHAR_9 = 8'h39;

  // Symbol count and pattern (1 = dash), first symbol in the highest used bit.
  localparam logic [CntW-1:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] LETTER_PAT [26] = '{
    4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
    4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
  };
  localparam logic [SymW-1:0] DIGIT_PAT [10] = '{
    5'h1F, 5'h0F, 5'h07, 5'h03, 5'h01, 5'h00, 5'h10, 5'h18, 5'h1C, 5'h1E
  };

  typedef enum logic [1:0] {
    CLS_SPACE,
    CLS_SYM,
    CLS_BAD
  } cls_t;

  // Decoded character: pattern left-aligned, current symbol in the top bit.
  typedef struct packed {
    cls_t            cls;
    logic [CntW-1:0] len;
    logic [SymW-1:0] pat;
  } dec_t;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_SPACE,
    ST_BAD,
    ST_LGAP,
    ST_SYM,
    ST_IGAP
  } step_t;

  typedef enum logic [2:0] {
    DUR_ZERO,
    DUR_ONE,
    DUR_THREE,
    DUR_SEVEN,
    DUR_SYM
  } dur_sel_t;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_SYM
  } last_sel_t;

  typedef enum logic [1:0] {
    PREV_KEEP,
    PREV_CLEAR,
    PREV_CLEAR_IF_EOM,
    PREV_SET_NOT_EOM
  } prev_op_t;

  typedef enum logic [1:0] {
    JMP_DISPATCH,
    JMP_GOTO,
    JMP_LAST
  } jmp_t;

  typedef struct packed {
    logic      emit;
    logic      led;
    dur_sel_t  dur;
    logic      bad;
    last_sel_t last;
    prev_op_t  prev;
    logic      shift;
    jmp_t      jmp;
    step_t     target;
  } ctl_t;

  // Control store: one word per step.
  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    w = '{emit: 1'b0, led: 1'b0, dur: DUR_ZERO, bad: 1'b0, last: LAST_NO,
          prev: PREV_KEEP, shift: 1'b0, jmp: JMP_DISPATCH, target: ST_FETCH};
    case (s)
      ST_FETCH: begin
        w.jmp = JMP_DISPATCH;
      end
      ST_SPACE: begin
        w.emit = 1'b1;
        w.dur = DUR_SEVEN;
        w.last = LAST_YES;
        w.prev = PREV_CLEAR;
        w.jmp = JMP_GOTO;
        w.target = ST_FETCH;
      end
      ST_BAD: begin
        w.emit = 1'b1;
        w.bad = 1'b1;
        w.last = LAST_YES;
        w.prev = PREV_CLEAR_IF_EOM;
        w.jmp = JMP_GOTO;
        w.target = ST_FETCH;
      end
      ST_LGAP: begin
        w.emit = 1'b1;
        w.dur = DUR_THREE;
        w.jmp = JMP_GOTO;
        w.target = ST_SYM;
      end
      ST_SYM: begin
        w.emit = 1'b1;
        w.led = 1'b1;
        w.dur = DUR_SYM;
        w.last = LAST_SYM;
        w.prev = PREV_SET_NOT_EOM;
        w.jmp = JMP_LAST;
        w.target = ST_IGAP;
      end
      ST_IGAP: begin
        w.emit = 1'b1;
        w.dur = DUR_ONE;
        w.shift = 1'b1;
        w.jmp = JMP_GOTO;
        w.target = ST_SYM;
      end
      default: begin
        w.jmp = JMP_GOTO;
        w.target = ST_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

@@ src/mte_char_decode.sv @@
// Character decoder: class, symbol count and left-aligned dot/dash pattern.
`timescale 1ns / 1ps

module mte_char_decode (
  input  logic [mte_pkg::CharW-1:0] char_code,
  output mte_pkg::dec_t             dec
);
  import mte_pkg::*;

  logic [4:0]      letter_idx;
  logic [3:0]      digit_idx;
  logic [CntW-1:0] lt_len;
  logic [3:0]      lt_pat;

  assign letter_idx = 5'(char_code - CHAR_A);
  assign digit_idx  = 4'(char_code - CHAR_0);

  always_comb begin
    lt_len = '0;
    lt_pat = '0;
    dec.cls = CLS_BAD;
    dec.len = CntW'(1);
    dec.pat = '0;
    if (char_code == CHAR_SPACE) begin
      dec.cls = CLS_SPACE;
    end else if (char_code >= CHAR_A && char_code <= CHAR_Z) begin
      lt_len = LETTER_LEN[letter_idx];
      lt_pat = LETTER_PAT[letter_idx];
      dec.cls = CLS_SYM;
      dec.len = lt_len;
      // move the first symbol up to the top bit
      dec.pat = SymW'({1'b0, lt_pat} << (CntW'(SymW) - lt_len));
    end else if (char_code >= CHAR_0 && char_code <= CHAR_9) begin
      dec.cls = CLS_SYM;
      dec.len = CntW'(SymW);
      dec.pat = DIGIT_PAT[digit_idx];
    end
  end

endmodule

@@ src/morse_timing_encoder.sv @@
// Top level of the Morse timing encoder: sequencer, datapath and stream ports.
//
//  Channel  Dir  Handshake              Payload
//  in_      in   in_tvalid/in_tready    tdata = char_code, tlast = end_of_message
//  out_     out  out_tvalid/out_tready  tdata = led_on, duration_ticks;
//                                       tlast = last_of_char, tuser = bad_char
//  cfg_     in   cfg_wr_en              cfg_wr_data = dot_ticks
//
// Each character is taken in the fetch step and then yields one word per segment:
// one word for a space or an unknown code, up to ten for a digit after a letter. The step
// counter walks the control store and emits at most one segment per cycle.
// rst_n (synchronous) returns the sequencer to fetch, clears the letter flag
// and sets dot_ticks to 100. A stalled out_tready holds any emitting step while
// a word is pending; a new character is taken only in the fetch step.
`timescale 1ns / 1ps

module morse_timing_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // config
  input  logic                            cfg_wr_en,
  input  logic [mte_pkg::DotW-1:0]        cfg_wr_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mte_pkg::CharW-1:0]       in_tdata,   // [7:0] char_code
  input  logic                            in_tlast,   // end_of_message
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mte_pkg::OutDataW-1:0]    out_tdata,  // [0] led_on, [19:1] duration_ticks
  output logic                            out_tlast,  // last_of_char
  output logic                            out_tuser   // bad_char
);
  import mte_pkg::*;

  step_t           step_r, step_nxt;
  logic [SymW-1:0] sym_r, sym_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            eom_r, eom_nxt;
  logic            prev_r, prev_nxt;
  logic [DotW-1:0] dot_r;

  logic            out_valid_r, out_valid_nxt;
  logic            out_led_r, out_led_nxt;
  logic [DurW-1:0] out_dur_r, out_dur_nxt;
  logic            out_bad_r, out_bad_nxt;
  logic            out_last_r, out_last_nxt;

  ctl_t            ctl;
  dec_t            dec;
  logic            out_free;
  logic            advance;
  logic            sym_last;
  logic [DurW-1:0] dot1, dot3, dot7, dur_val;
  logic            last_val;

  mte_char_decode u_dec (
    .char_code (in_tdata),
    .dec       (dec)
  );

  assign ctl       = ucode(step_r);
  assign in_tready = (step_r == ST_FETCH);
  assign out_free  = !out_valid_r || out_tready;
  assign sym_last  = (cnt_r == CntW'(1));

  assign dot1 = DurW'(dot_r);
  assign dot3 = (dot1 << 1) + dot1;
  assign dot7 = (dot1 << 3) - dot1;

  always_comb begin
    case (ctl.dur)
      DUR_ZERO:  dur_val = '0;
      DUR_ONE:   dur_val = dot1;
      DUR_THREE: dur_val = dot3;
      DUR_SEVEN: dur_val = dot7;
      DUR_SYM:   dur_val = sym_r[SymW-1] ? dot3 : dot1;
      default:   dur_val = '0;
    endcase
  end

  always_comb begin
    case (ctl.last)
      LAST_NO:  last_val = 1'b0;
      LAST_YES: last_val = 1'b1;
      LAST_SYM: last_val = sym_last;
      default:  last_val = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    sym_nxt       = sym_r;
    cnt_nxt       = cnt_r;
    eom_nxt       = eom_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    out_led_nxt   = out_led_r;
    out_dur_nxt   = out_dur_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;
    advance       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (ctl.emit) begin
      // hold the step until the output register can take the word
      if (out_free) begin
        advance       = 1'b1;
        out_valid_nxt = 1'b1;
        out_led_nxt   = ctl.led;
        out_dur_nxt   = dur_val;
        out_bad_nxt   = ctl.bad;
        out_last_nxt  = last_val;
      end
    end else begin
      advance = in_tvalid;
    end

    if (advance) begin
      case (ctl.prev)
        PREV_KEEP:         prev_nxt = prev_r;
        PREV_CLEAR:        prev_nxt = 1'b0;
        PREV_CLEAR_IF_EOM: prev_nxt = prev_r && !eom_r;
        PREV_SET_NOT_EOM:  prev_nxt = sym_last ? !eom_r : prev_r;
        default:           prev_nxt = prev_r;
      endcase

      if (ctl.shift) begin
        sym_nxt = sym_r << 1;
        cnt_nxt = cnt_r - CntW'(1);
      end

      case (ctl.jmp)
        JMP_DISPATCH: begin
          sym_nxt = dec.pat;
          cnt_nxt = dec.len;
          eom_nxt = in_tlast;
          case (dec.cls)
            CLS_SPACE: step_nxt = ST_SPACE;
            CLS_SYM:   step_nxt = prev_r ? ST_LGAP : ST_SYM;
            CLS_BAD:   step_nxt = ST_BAD;
            default:   step_nxt = ST_BAD;
          endcase
        end
        JMP_GOTO: step_nxt = ctl.target;
        JMP_LAST: step_nxt = sym_last ? ST_FETCH : ctl.target;
        default:  step_nxt = ST_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_FETCH;
      prev_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dot_r       <= DOT_TICKS_RST;
    end else begin
      step_r      <= step_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        dot_r <= cfg_wr_data;
      end
    end
    sym_r      <= sym_nxt;
    cnt_r      <= cnt_nxt;
    eom_r      <= eom_nxt;
    out_led_r  <= out_led_nxt;
    out_dur_r  <= out_dur_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW - DurW - 1)'(0), out_dur_r, out_led_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  // every accepted character yields at least one word before the next fetch
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sequencer back in fetch right after taking a character");

  // a word that is not the last of its character means the sequencer is mid-character
  a_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("fetch while a character still has segments pending");

  // an invalid character is a single dark zero-length word
  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && !out_tdata[0] && out_tdata[19:1] == '0))
    else $error("malformed invalid-character word");

  // lit segments only come from valid characters
  a_lit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> !out_tuser)
    else $error("lit segment flagged as invalid");

endmodule
